// ===== sv/pfgb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfgb_pkg
// Types and constants shared by the page frame store glyph blitter.
// ----------------------------------------------------------------------------
package pfgb_pkg;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_GLYPH = 2'd1,
		OP_NEXT  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] cursor_x;
		logic [15:0] cursor_y;
		logic [7:0]  glyph_byte;
		logic [6:0]  glyph_width;
		logic        inverse;
		logic [6:0]  read_column;
		logic [2:0]  read_page;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [15:0] cursor_x_now;
		logic [15:0] cursor_y_now;
		logic        glyph_done;
	} result_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_WR_A,
		ST_WR_B,
		ST_FIN
	} state_t;

	// One access request to the shared read-modify-write unit.
	typedef struct packed {
		logic        issue;
		logic        write;
		logic [15:0] col;
		logic [12:0] page;
		logic [7:0]  data;
		logic [7:0]  mask;
	} rmw_req_t;

	localparam logic       REG_GLYPH_HEIGHT = 1'b0;
	localparam logic [6:0] HEIGHT_RESET     = 7'd12;
	localparam logic [6:0] MAX_HEIGHT       = 7'd64;
	localparam logic [15:0] LINE_STEP       = 16'd16;

endpackage

// ===== sv/pfgb_ram.sv =====
// ----------------------------------------------------------------------------
// pfgb_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pfgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/pfgb_rmw.sv =====
// ----------------------------------------------------------------------------
// pfgb_rmw
// Shared read-modify-write unit: maps a column and page to a store address,
// clips against the frame, and merges masked bits into the byte read back.
// ----------------------------------------------------------------------------
module pfgb_rmw import pfgb_pkg::*; #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 64,
	localparam int PAGES     = (FRAME_HEIGHT + 7) / 8,
	localparam int DEPTH     = FRAME_WIDTH * PAGES,
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW        = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1,
	localparam int PW        = (PAGES > 1) ? $clog2(PAGES) : 1,
	localparam int LAST_ROWS = FRAME_HEIGHT - 8 * (PAGES - 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rmw_req_t      req,
	output logic [AW-1:0] rd_addr,
	input  logic [7:0]    rd_data,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output logic [7:0]    wr_data,
	output logic [7:0]    rd_byte
);

	localparam logic [7:0] LAST_MASK = 8'((1 << LAST_ROWS) - 1);

	logic          in_frame;
	logic [7:0]    frame_mask;
	logic          valid_s1;
	logic          write_s1;
	logic          in_frame_s1;
	logic [AW-1:0] addr_s1;
	logic [7:0]    data_s1;
	logic [7:0]    mask_s1;

	assign in_frame   = (req.col < 16'(FRAME_WIDTH)) && (req.page < 13'(PAGES));
	assign rd_addr    = AW'(req.col[CW-1:0]) * AW'(PAGES) + AW'(req.page[PW-1:0]);
	assign frame_mask = (req.page == 13'(PAGES - 1)) ? LAST_MASK : 8'hFF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (req.issue) begin
			write_s1    <= req.write;
			in_frame_s1 <= in_frame;
			addr_s1     <= rd_addr;
			data_s1     <= req.data;
			mask_s1     <= req.mask & frame_mask;
		end
	end

	assign wr_en   = valid_s1 && write_s1 && in_frame_s1;
	assign wr_addr = addr_s1;
	assign wr_data = (rd_data & ~mask_s1) | (data_s1 & mask_s1);
	assign rd_byte = in_frame_s1 ? rd_data : 8'h00;

endmodule

// ===== sv/page_framebuffer_glyph_blit.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_glyph_blit
// Monochrome page frame store with a text cursor and a glyph column blitter.
// ----------------------------------------------------------------------------
// Set cursor, next line and a glyph byte at height zero go from ST_RD_A
// straight to ST_FIN; a frame read passes through ST_WR_A, and a glyph byte
// through ST_WR_A and ST_WR_B, its two read-modify-write passes through the
// shared merge unit. result_valid rises once ST_FIN commits. One transaction
// is in work at a time; ST_FIN waits for the result register to be free.
// After reset all FRAME_WIDTH*ceil(FRAME_HEIGHT/8) bytes (1024) are cleared.
// ----------------------------------------------------------------------------
module page_framebuffer_glyph_blit import pfgb_pkg::*; #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PAGES = (FRAME_HEIGHT + 7) / 8;
	localparam int DEPTH = FRAME_WIDTH * PAGES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t        state_q, state_d;
	item_t         item_q;
	logic [6:0]    height_q;
	logic [15:0]   cur_col_q, cur_row_q;
	logic [3:0]    pg_cnt_q;
	logic [6:0]    col_cnt_q;
	logic [AW-1:0] clr_q;
	logic [7:0]    rd_q;
	logic          result_valid_q;
	result_t       result_q;

	// Sequencer outputs.
	rmw_req_t      req;
	logic          clearing;
	logic          capture_rd;
	logic          commit;

	// Frame store and merge unit wiring.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic          rmw_we;
	logic [AW-1:0] rmw_waddr;
	logic [7:0]    rmw_wdata;
	logic [7:0]    rmw_rd_byte;

	// Glyph geometry for the item in work.
	logic [6:0]    h_eff;
	logic [6:0]    h_sum;
	logic [3:0]    pages_n;
	logic [2:0]    rem;
	logic          glyph_on;
	logic          last_page;
	logic          col_end;
	logic [7:0]    row_mask;
	logic [7:0]    glyph_bits;
	logic [15:0]   y0;
	logic [12:0]   page0;
	logic [15:0]   x_col;
	logic [15:0]   win;
	logic [15:0]   msk;

	// Cursor and glyph position after the item.
	logic [15:0]   nx_col, nx_row;
	logic [3:0]    nx_pg;
	logic [6:0]    nx_cc;
	logic          nx_done;
	logic          cfg_wr;

	// ------------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is tied
	// high so no access is held in wait states.
	// ------------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_GLYPH_HEIGHT) ? {25'd0, height_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr && (paddr[2] == REG_GLYPH_HEIGHT)) begin
			height_q <= pwdata[6:0];
		end
	end

	// ------------------------------------------------------------------------
	// Glyph geometry. Heights above 64 behave as 64. The byte is placed at
	// row offset y0[2:0] inside page y0[15:3]; the 16-bit window then splits
	// into the low half for that page and the high half for the next one, and
	// the 13-bit page number wraps the same way the 16-bit row does.
	// ------------------------------------------------------------------------
	assign h_eff     = (height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q;
	assign h_sum     = h_eff + 7'd7;
	assign pages_n   = h_sum[6:3];
	assign rem       = h_eff[2:0];
	assign glyph_on  = (pages_n != 4'd0);
	assign last_page = ({1'b0, pg_cnt_q} + 5'd1) >= {1'b0, pages_n};
	assign col_end   = ({1'b0, col_cnt_q} + 8'd1) >= {1'b0, item_q.glyph_width};
	assign row_mask  = (last_page && (rem != 3'd0)) ? ~(8'hFF << rem) : 8'hFF;
	assign glyph_bits = (item_q.glyph_byte ^ {8{item_q.inverse}}) & row_mask;
	assign y0        = cur_row_q + {9'd0, pg_cnt_q, 3'd0};
	assign page0     = y0[15:3];
	assign x_col     = cur_col_q + {9'd0, col_cnt_q};
	assign win       = {8'h00, glyph_bits} << y0[2:0];
	assign msk       = {8'h00, row_mask} << y0[2:0];

	// Cursor update, applied when the result is loaded.
	always_comb begin
		nx_col  = cur_col_q;
		nx_row  = cur_row_q;
		nx_pg   = pg_cnt_q;
		nx_cc   = col_cnt_q;
		nx_done = 1'b0;
		case (item_q.op)
			OP_SET: begin
				nx_col = item_q.cursor_x;
				nx_row = item_q.cursor_y;
				nx_pg  = 4'd0;
				nx_cc  = 7'd0;
			end
			OP_GLYPH: begin
				if (glyph_on) begin
					if (col_end) begin
						nx_cc = 7'd0;
						if (last_page) begin
							nx_pg   = 4'd0;
							nx_col  = cur_col_q + {9'd0, item_q.glyph_width};
							nx_done = 1'b1;
						end else begin
							nx_pg = pg_cnt_q + 4'd1;
						end
					end else begin
						nx_cc = col_cnt_q + 7'd1;
					end
				end
			end
			OP_NEXT: begin
				nx_col = 16'd0;
				nx_row = cur_row_q + LINE_STEP;
				nx_pg  = 4'd0;
				nx_cc  = 7'd0;
			end
			default: begin
				nx_col = cur_col_q;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer. A glyph byte reads page A, then writes A while reading page B,
	// then writes B. A frame read uses only the first pass. FIN waits for the
	// result register to be free before committing the new cursor.
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					state_d = ST_RD_A;
				end
			end
			ST_RD_A: begin
				if ((item_q.op == OP_READ) || ((item_q.op == OP_GLYPH) && glyph_on)) begin
					state_d = ST_WR_A;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_WR_A: begin
				if (item_q.op == OP_READ) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_WR_B;
				end
			end
			ST_WR_B: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!result_valid_q || result_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		item_ready = 1'b0;
		clearing   = 1'b0;
		capture_rd = 1'b0;
		commit     = 1'b0;
		req        = '0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
			end
			ST_IDLE: begin
				item_ready = 1'b1;
			end
			ST_RD_A: begin
				if (item_q.op == OP_READ) begin
					req.issue = 1'b1;
					req.write = 1'b0;
					req.col   = {9'd0, item_q.read_column};
					req.page  = {10'd0, item_q.read_page};
				end else if ((item_q.op == OP_GLYPH) && glyph_on) begin
					req.issue = 1'b1;
					req.write = 1'b1;
					req.col   = x_col;
					req.page  = page0;
					req.data  = win[7:0];
					req.mask  = msk[7:0];
				end
			end
			ST_WR_A: begin
				capture_rd = 1'b1;
				if (item_q.op == OP_GLYPH) begin
					req.issue = 1'b1;
					req.write = (msk[15:8] != 8'h00);
					req.col   = x_col;
					req.page  = page0 + 13'd1;
					req.data  = win[15:8];
					req.mask  = msk[15:8];
				end
			end
			ST_WR_B: begin
				req = '0;
			end
			ST_FIN: begin
				commit = !result_valid_q || result_ready;
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			cur_col_q <= 16'd0;
			cur_row_q <= 16'd0;
			pg_cnt_q  <= 4'd0;
			col_cnt_q <= 7'd0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + AW'(1);
			end
			if (commit) begin
				cur_col_q <= nx_col;
				cur_row_q <= nx_row;
				pg_cnt_q  <= nx_pg;
				col_cnt_q <= nx_cc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
		if (capture_rd) begin
			rd_q <= rmw_rd_byte;
		end
	end

	// ------------------------------------------------------------------------
	// Result register. It frees the input side: a new transaction is taken
	// while the previous result still waits for result_ready.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (commit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q.read_data    <= (item_q.op == OP_READ) ? rd_q : 8'h00;
			result_q.cursor_x_now <= nx_col;
			result_q.cursor_y_now <= nx_row;
			result_q.glyph_done   <= nx_done;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// ------------------------------------------------------------------------
	// Frame store and the shared merge unit. The clearing pass owns the write
	// port right after reset; afterwards only the merge unit writes.
	// ------------------------------------------------------------------------
	pfgb_rmw #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_rmw (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.wr_en   (rmw_we),
		.wr_addr (rmw_waddr),
		.wr_data (rmw_wdata),
		.rd_byte (rmw_rd_byte)
	);

	assign ram_we    = clearing || rmw_we;
	assign ram_waddr = clearing ? clr_q : rmw_waddr;
	assign ram_wdata = clearing ? 8'h00 : rmw_wdata;

	pfgb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	a_merge_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		rmw_we |-> (state_q == ST_WR_A) || (state_q == ST_WR_B))
		else $error("merge unit wrote outside a write phase");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> state_q == ST_RD_A)
		else $error("accepted transaction did not start the sequencer");

	a_page_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		pg_cnt_q <= 4'd7)
		else $error("glyph page count ran past the last page");

	a_read_single_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && ($past(state_q) == ST_WR_A) |-> item_q.op == OP_READ)
		else $error("glyph byte skipped its second pass");

	a_no_issue_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.issue && !item_ready)
		else $error("access issued during the clearing pass");

endmodule

// ===== tb/pfgb_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// pfgb_tb_pkg
// Frame store tracker for the glyph blitter testbench: it keeps its own copy
// of the frame, cursor and glyph position and checks each result in order.
// ----------------------------------------------------------------------------
package pfgb_tb_pkg;
	import pfgb_pkg::*;

	localparam int FRAME_COLS  = 128;
	localparam int FRAME_ROWS  = 64;
	localparam int FRAME_PAGES = (FRAME_ROWS + 7) / 8;

	class frame_tracker;
		logic [7:0]  frame [FRAME_COLS*FRAME_PAGES];
		logic [15:0] cur_col;
		logic [15:0] cur_row;
		logic [3:0]  page_idx;
		logic [6:0]  col_idx;
		logic [6:0]  height;
		result_t     pending_results [$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			foreach (frame[i]) frame[i] = 8'h00;
			cur_col    = '0;
			cur_row    = '0;
			page_idx   = '0;
			col_idx    = '0;
			height     = HEIGHT_RESET;
			mismatches = 0;
			checked    = 0;
		endfunction

		function void set_height(logic [6:0] value);
			height = value;
		endfunction

		function int unsigned glyph_pages();
			int unsigned h;
			h = 32'((height > MAX_HEIGHT) ? MAX_HEIGHT : height);
			return (h + 7) >> 3;
		endfunction

		// Draws one glyph column byte and steps the position inside the glyph.
		// Returns 1 when the byte completed the glyph; at height zero it does nothing.
		function logic blit(logic [7:0] data, logic [6:0] width, logic inv);
			int unsigned h, pages, rem, rows, x, y, y0, i;
			logic        is_last;
			h     = 32'((height > MAX_HEIGHT) ? MAX_HEIGHT : height);
			pages = (h + 7) >> 3;
			rem   = h & 7;
			if (pages == 0)
				return 1'b0;
			is_last = (32'(page_idx) + 1 >= pages);
			rows    = (is_last && rem != 0) ? rem : 8;
			x       = (32'(cur_col) + 32'(col_idx)) & 32'hFFFF;
			y0      = 32'(cur_row) + 32'(page_idx) * 8;
			for (i = 0; i < rows; i++) begin
				y = (y0 + i) & 32'hFFFF;
				if (x < FRAME_COLS && y < FRAME_ROWS)
					frame[x*FRAME_PAGES + (y >> 3)][y & 7] = data[i] ^ inv;
			end
			if (32'(col_idx) + 1 >= 32'(width)) begin
				col_idx = '0;
				if (is_last) begin
					page_idx = '0;
					cur_col  = cur_col + 16'(width);
					return 1'b1;
				end
				page_idx = page_idx + 4'd1;
			end else begin
				col_idx = col_idx + 7'd1;
			end
			return 1'b0;
		endfunction

		function void note_item(item_t it);
			result_t want;
			want = '0;
			case (it.op)
				OP_SET: begin
					cur_col  = it.cursor_x;
					cur_row  = it.cursor_y;
					page_idx = '0;
					col_idx  = '0;
				end
				OP_GLYPH: begin
					want.glyph_done = blit(it.glyph_byte, it.glyph_width, it.inverse);
				end
				OP_NEXT: begin
					cur_col  = '0;
					cur_row  = cur_row + LINE_STEP;
					page_idx = '0;
					col_idx  = '0;
				end
				OP_READ: begin
					want.read_data = frame[int'(it.read_column)*FRAME_PAGES + int'(it.read_page)];
				end
				default: begin
				end
			endcase
			want.cursor_x_now = cur_col;
			want.cursor_y_now = cur_row;
			pending_results.push_back(want);
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH: %s", msg);
		endtask

		task check_result(result_t got);
			result_t want;
			checked++;
			if (pending_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", checked));
				return;
			end
			want = pending_results.pop_front();
			if (got.read_data !== want.read_data)
				report($sformatf("result %0d read_data got %0h expected %0h",
					checked, got.read_data, want.read_data));
			if (got.cursor_x_now !== want.cursor_x_now)
				report($sformatf("result %0d cursor_x_now got %0h expected %0h",
					checked, got.cursor_x_now, want.cursor_x_now));
			if (got.cursor_y_now !== want.cursor_y_now)
				report($sformatf("result %0d cursor_y_now got %0h expected %0h",
					checked, got.cursor_y_now, want.cursor_y_now));
			if (got.glyph_done !== want.glyph_done)
				report($sformatf("result %0d glyph_done got %0b expected %0b",
					checked, got.glyph_done, want.glyph_done));
		endtask
	endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the page frame store glyph blitter. Items go in over a
// valid/ready channel, each result is checked in order against a tracker
// that keeps its own frame, and glyph_height is changed over APB between
// phases. Both channels stall at random, apart from one steady phase.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfgb_pkg::*;
	import pfgb_tb_pkg::*;

	// The store clear after reset runs with item_ready low, so the quiet
	// limit sits well above the length of that clear.
	localparam int IDLE_LIMIT      = 5000;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int TAIL_CYCLES     = 10;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	item_t       item;
	logic        result_valid;
	logic        result_ready;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	frame_tracker tracker = new();

	// When steady is set neither side inserts idle cycles.
	logic        steady;
	// Counts every item sent.
	int unsigned fed;
	// Item count at which the current phase stops sending.
	int unsigned phase_stop;

	page_framebuffer_glyph_blit u_top (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// The receiver drops result_ready at random, with a 17 percent chance, unless steady.
	always @(negedge clk) begin
		result_ready <= steady || ($urandom_range(99) >= 17);
	end

	// Every result transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			tracker.check_result(result);
	end

	// The watchdog ends the run when no transaction moves for too long.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// A random item: every field carries random bits, so the fields that an
	// operation does not use still toggle.
	function automatic item_t noise_item();
		item_t it;
		it.op          = op_t'($urandom_range(3));
		it.cursor_x    = 16'($urandom);
		it.cursor_y    = 16'($urandom);
		it.glyph_byte  = 8'($urandom);
		it.glyph_width = 7'($urandom);
		it.inverse     = 1'($urandom);
		it.read_column = 7'($urandom);
		it.read_page   = 3'($urandom);
		return it;
	endfunction

	function automatic item_t set_item(logic [15:0] x, logic [15:0] y);
		item_t it;
		it          = noise_item();
		it.op       = OP_SET;
		it.cursor_x = x;
		it.cursor_y = y;
		return it;
	endfunction

	function automatic item_t glyph_item(logic [7:0] data, logic [6:0] width, logic inv);
		item_t it;
		it             = noise_item();
		it.op          = OP_GLYPH;
		it.glyph_byte  = data;
		it.glyph_width = width;
		it.inverse     = inv;
		return it;
	endfunction

	function automatic item_t next_item();
		item_t it;
		it    = noise_item();
		it.op = OP_NEXT;
		return it;
	endfunction

	function automatic item_t read_item(logic [6:0] col, logic [2:0] pg);
		item_t it;
		it             = noise_item();
		it.op          = OP_READ;
		it.read_column = col;
		it.read_page   = pg;
		return it;
	endfunction

	// Sends one item. Called at a falling edge, returns at a falling edge
	// with item_valid still high so back-to-back items need no gap.
	task automatic push_item(input item_t it);
		if (!steady && $urandom_range(99) < 17) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		tracker.note_item(it);
		fed++;
		@(negedge clk);
	endtask

	// Drops item_valid and waits until every expected result has come back.
	task automatic hold_sender();
		item_valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(negedge clk);
	endtask

	// APB write of glyph_height, done only with the block drained.
	task automatic write_height(input logic [6:0] value);
		hold_sender();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_GLYPH_HEIGHT, 2'b00};
		pwdata  <= {25'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_height(value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Directed items at the reset height of 12 rows: two pages, the second
	// one partial with four rows.
	task automatic directed_items();
		// The store must read back as cleared at both corners.
		push_item(read_item(7'd0, 3'd0));
		push_item(read_item(7'd127, 3'd7));
		// A two-column glyph at the origin; the bytes of the second page draw
		// only their low four bits.
		push_item(set_item(16'd0, 16'd0));
		push_item(glyph_item(8'hFF, 7'd2, 1'b0));
		push_item(glyph_item(8'h81, 7'd2, 1'b0));
		push_item(glyph_item(8'hFF, 7'd2, 1'b0));
		push_item(glyph_item(8'hF5, 7'd2, 1'b0));
		push_item(read_item(7'd0, 3'd0));
		push_item(read_item(7'd0, 3'd1));
		push_item(read_item(7'd1, 3'd1));
		// An inverted glyph at the bottom right corner, clipped on both edges.
		push_item(set_item(16'd127, 16'd60));
		repeat (4) push_item(glyph_item(8'hA5, 7'd2, 1'b1));
		push_item(read_item(7'd127, 3'd7));
		// Both coordinates wrap at 16 bits and land back at the top left.
		push_item(set_item(16'hFFFF, 16'hFFFA));
		push_item(glyph_item(8'h3C, 7'd2, 1'b0));
		push_item(glyph_item(8'hC3, 7'd2, 1'b0));
		push_item(glyph_item(8'h0F, 7'd2, 1'b0));
		push_item(glyph_item(8'hF0, 7'd2, 1'b1));
		push_item(read_item(7'd0, 3'd0));
		// Next line from a wrapped row, then a zero-width glyph that ends
		// each page on every byte and leaves the cursor column in place.
		push_item(next_item());
		push_item(glyph_item(8'hFF, 7'd0, 1'b0));
		push_item(glyph_item(8'h00, 7'd0, 1'b1));
		// Cursor at the largest values, then next line wraps the row.
		push_item(set_item(16'hFFFF, 16'hFFFF));
		push_item(next_item());
	endtask

	// A well-formed text run: place the cursor, draw one to three whole
	// glyphs, and read back bytes around where they landed. Now and then a
	// stray item breaks a glyph in the middle, and the end of a phase cuts
	// the glyph bytes short.
	task automatic glyph_run();
		logic [15:0] x0;
		logic [15:0] y0;
		logic [6:0]  w;
		logic        inv;
		int unsigned pages;
		int unsigned pick;
		case ($urandom_range(9))
			0: begin
				x0 = 16'hFFFF - 16'($urandom_range(7));
				y0 = 16'($urandom);
			end
			1: begin
				x0 = 16'($urandom_range(120, 127));
				y0 = 16'($urandom_range(48, 63));
			end
			2: begin
				x0 = 16'($urandom);
				y0 = 16'hFFFF - 16'($urandom_range(15));
			end
			default: begin
				x0 = 16'($urandom_range(127));
				y0 = 16'($urandom_range(63));
			end
		endcase
		push_item(set_item(x0, y0));
		repeat ($urandom_range(1, 3)) begin
			pick = $urandom_range(99);
			if (pick < 2)
				w = 7'($urandom_range(65, 127));
			else if (pick < 5)
				w = 7'd0;
			else if (pick < 15)
				w = 7'($urandom_range(9, 64));
			else
				w = 7'($urandom_range(1, 8));
			inv = 1'($urandom_range(1));
			// At height zero the bytes are still sent; the block ignores them.
			pages = tracker.glyph_pages();
			if (pages == 0)
				pages = 2;
			repeat (pages * ((w == 0) ? 1 : w)) begin
				if (fed >= phase_stop)
					break;
				if ($urandom_range(49) == 0)
					push_item(noise_item());
				push_item(glyph_item(8'($urandom), w,
					($urandom_range(19) == 0) ? ~inv : inv));
			end
			if ($urandom_range(4) == 0)
				push_item(next_item());
		end
		repeat ($urandom_range(2, 5))
			push_item(read_item(7'(x0 + 16'($urandom_range(8))),
				3'((y0 >> 3) + 16'($urandom_range(8)))));
	endtask

	task automatic run_phase(input int unsigned n);
		phase_stop = fed + n;
		while (fed < phase_stop) begin
			if ($urandom_range(99) < 70)
				glyph_run();
			else
				repeat ($urandom_range(1, 5)) push_item(noise_item());
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		steady       = 1'b0;
		fed          = 0;
		phase_stop   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The first phase runs at the reset height.
		directed_items();
		run_phase(ITEMS_PER_PHASE);

		// One-row glyphs: a single partial page.
		write_height(7'd1);
		run_phase(ITEMS_PER_PHASE);

		// Exactly one full page, with no stalls on either side.
		steady <= 1'b1;
		write_height(7'd8);
		run_phase(ITEMS_PER_PHASE);
		steady <= 1'b0;

		// Full frame height; partway through, the sender waits for the block
		// to drain completely before going on.
		write_height(7'd64);
		run_phase(ITEMS_PER_PHASE / 2);
		hold_sender();
		run_phase(ITEMS_PER_PHASE / 2);

		// Height zero: glyph bytes change nothing.
		write_height(7'd0);
		run_phase(ITEMS_PER_PHASE);

		// Heights above 64 behave as 64.
		write_height(7'd127);
		run_phase(ITEMS_PER_PHASE);
		write_height(7'd65);
		run_phase(ITEMS_PER_PHASE);

		write_height(7'd7);
		run_phase(ITEMS_PER_PHASE);
		write_height(7'd16);
		run_phase(ITEMS_PER_PHASE);
		write_height(7'($urandom_range(1, 64)));
		run_phase(ITEMS_PER_PHASE);

		// Drain, then let the block run on idle to show any stray result.
		hold_sender();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
